// ===== rtl/core/mcpg_pkg.sv =====
// mcpg_pkg: field widths, shape codes, point order table and the walk state type
// shared by the midpoint circle core, its walk unit and its checker
// depends on nothing
package mcpg_pkg;

    localparam int COORD_BITS = 12;
    localparam int OUT_W    = 14;
    localparam int CIN_W    = COORD_BITS;
    localparam int RAD_W    = 11;
    localparam int SHAPE_W  = 3;
    localparam int OFS_W    = 12;
    localparam int STEP_W   = 13;
    localparam int ERR_W    = 16;
    localparam int IDX_W    = 3;
    localparam int DIAM_W   = RAD_W + 1;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;

    // func codes carried on tuser
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_STEP  = 1'b1;

    localparam logic [SHAPE_W-1:0] SHAPE_TOP    = 3'd0;
    localparam logic [SHAPE_W-1:0] SHAPE_BOTTOM = 3'd1;
    localparam logic [SHAPE_W-1:0] SHAPE_LEFT   = 3'd2;
    localparam logic [SHAPE_W-1:0] SHAPE_RIGHT  = 3'd3;
    localparam logic [SHAPE_W-1:0] SHAPE_FULL   = 3'd4;

    // bit positions of a point code
    localparam int PT_SWAP_BIT = 0;
    localparam int PT_NEGX_BIT = 1;
    localparam int PT_NEGY_BIT = 2;

    typedef struct packed {
        logic signed [OFS_W-1:0]  x_ofs;
        logic signed [OFS_W-1:0]  y_ofs;
        logic        [STEP_W-1:0] step_x;
        logic        [STEP_W-1:0] step_y;
        logic signed [ERR_W-1:0]  err;
        logic        [IDX_W-1:0]  idx;
        logic                     busy;
    } walk_t;

    // swap / negate code of each point of an iteration, in emit order
    function automatic logic [2:0] pt_code(input logic [SHAPE_W-1:0] shape,
                                           input logic [IDX_W-1:0] idx);
        logic [2:0] code;
        code = 3'd0;
        case (shape)
            SHAPE_TOP: begin
                case (idx)
                    3'd0:    code = 3'd4;
                    3'd1:    code = 3'd6;
                    3'd2:    code = 3'd5;
                    3'd3:    code = 3'd7;
                    default: code = 3'd0;
                endcase
            end
            SHAPE_BOTTOM: begin
                case (idx)
                    3'd0:    code = 3'd0;
                    3'd1:    code = 3'd2;
                    3'd2:    code = 3'd1;
                    3'd3:    code = 3'd3;
                    default: code = 3'd0;
                endcase
            end
            SHAPE_LEFT: begin
                case (idx)
                    3'd0:    code = 3'd6;
                    3'd1:    code = 3'd2;
                    3'd2:    code = 3'd7;
                    3'd3:    code = 3'd3;
                    default: code = 3'd0;
                endcase
            end
            SHAPE_RIGHT: begin
                case (idx)
                    3'd0:    code = 3'd4;
                    3'd1:    code = 3'd0;
                    3'd2:    code = 3'd5;
                    3'd3:    code = 3'd1;
                    default: code = 3'd0;
                endcase
            end
            SHAPE_FULL: begin
                case (idx)
                    3'd0:    code = 3'd4;
                    3'd1:    code = 3'd0;
                    3'd2:    code = 3'd6;
                    3'd3:    code = 3'd2;
                    3'd4:    code = 3'd5;
                    3'd5:    code = 3'd1;
                    3'd6:    code = 3'd7;
                    default: code = 3'd3;
                endcase
            end
            default: code = 3'd0;
        endcase
        return code;
    endfunction

    // index of the last point of an iteration
    function automatic logic [IDX_W-1:0] pt_last_idx(input logic [SHAPE_W-1:0] shape);
        logic [IDX_W-1:0] li;
        li = (shape == SHAPE_FULL) ? 3'd7 : 3'd3;
        return li;
    endfunction

endpackage

// ===== rtl/core/mcpg_walk.sv =====
// mcpg_walk: point offset for the current walk position and the walk state
// after that point, including the midpoint error update at iteration end
// depends on mcpg_pkg
module mcpg_walk (
    input  mcpg_pkg::walk_t                         cur,
    input  logic [mcpg_pkg::SHAPE_W-1:0]            shape,
    input  logic [mcpg_pkg::DIAM_W-1:0]             diam,
    output mcpg_pkg::walk_t                         nxt,
    output logic signed [mcpg_pkg::OUT_W-1:0]       dx,
    output logic signed [mcpg_pkg::OUT_W-1:0]       dy,
    output logic                                    is_last
);
    import mcpg_pkg::*;

    logic [2:0]               code;
    logic signed [OFS_W-1:0]  ofs_a;
    logic signed [OFS_W-1:0]  ofs_b;
    logic signed [OUT_W-1:0]  dx_raw;
    logic signed [OUT_W-1:0]  dy_raw;
    logic                     iter_end;
    logic                     adv_y;
    logic                     ret_x;
    logic signed [ERR_W-1:0]  err_a;
    logic signed [ERR_W-1:0]  err_b;
    logic signed [OFS_W-1:0]  y_a;
    logic signed [OFS_W-1:0]  x_b;
    logic [STEP_W-1:0]        sy_a;
    logic [STEP_W-1:0]        sx_b;
    logic                     done;

    always_comb begin
        code   = pt_code(shape, cur.idx);
        ofs_a  = code[PT_SWAP_BIT] ? cur.y_ofs : cur.x_ofs;
        ofs_b  = code[PT_SWAP_BIT] ? cur.x_ofs : cur.y_ofs;
        dx_raw = OUT_W'(ofs_a);
        dy_raw = OUT_W'(ofs_b);
        dx     = code[PT_NEGX_BIT] ? -dx_raw : dx_raw;
        dy     = code[PT_NEGY_BIT] ? -dy_raw : dy_raw;
    end

    // advance y when error <= 0, then retreat x when the new error > 0
    always_comb begin
        iter_end = (cur.idx == pt_last_idx(shape));
        adv_y    = cur.err[ERR_W-1] || (cur.err == '0);
        err_a    = adv_y ? cur.err + ERR_W'(cur.step_y) : cur.err;
        y_a      = adv_y ? cur.y_ofs + OFS_W'(1) : cur.y_ofs;
        sy_a     = adv_y ? cur.step_y + STEP_W'(2) : cur.step_y;
        ret_x    = !err_a[ERR_W-1] && (err_a != '0);
        x_b      = ret_x ? cur.x_ofs - OFS_W'(1) : cur.x_ofs;
        sx_b     = ret_x ? cur.step_x + STEP_W'(2) : cur.step_x;
        err_b    = ret_x ? err_a + ERR_W'(sx_b) - ERR_W'(diam) : err_a;
        done     = (x_b < y_a);

        nxt = cur;
        if (iter_end) begin
            nxt.x_ofs  = x_b;
            nxt.y_ofs  = y_a;
            nxt.step_x = sx_b;
            nxt.step_y = sy_a;
            nxt.err    = err_b;
            nxt.idx    = '0;
            nxt.busy   = !done;
        end else begin
            nxt.idx = cur.idx + IDX_W'(1);
        end
        is_last = iter_end && done;
    end

endmodule

// ===== rtl/core/midpoint_circle_point_generator_core.sv =====
// midpoint_circle_point_generator_core: midpoint circle rasterizer, one point per step word
// depends on mcpg_pkg and mcpg_walk
//
//  channel | direction | payload
//  s_axis  | in        | tuser: func; tdata: centre_x, centre_y, radius, shape
//  m_axis  | out       | tdata: point_x, point_y; tlast: last point of the circle
//
// one word per cycle unless held back; a point goes from input register to output register
// the walk state updates in the same cycle a word leaves the input register
// start words and steps while idle give no point and never wait on m_axis_tready
// a stalled point in the output register holds back only the next point-producing word
// aresetn clears the walk to idle and empties both registers
module midpoint_circle_point_generator_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // centre_x [11:0], centre_y [23:12], radius [34:24], shape [37:35], zero fill
    input  logic [mcpg_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // func [0]
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // point_x [13:0], point_y [27:14], zero fill
    output logic [mcpg_pkg::M_DATA_W-1:0]   m_axis_tdata,
    output logic                            m_axis_tlast
);
    import mcpg_pkg::*;

    // input register
    logic                    stg_valid_reg, stg_valid_next;
    logic                    stg_func_reg;
    logic [CIN_W-1:0]        stg_cx_reg;
    logic [CIN_W-1:0]        stg_cy_reg;
    logic [RAD_W-1:0]        stg_rad_reg;
    logic [SHAPE_W-1:0]      stg_shape_reg;

    // circle held from the start word
    logic [COORD_BITS-1:0]   cx_reg, cx_next;
    logic [COORD_BITS-1:0]   cy_reg, cy_next;
    logic [SHAPE_W-1:0]      shape_reg, shape_next;
    logic [DIAM_W-1:0]       diam_reg, diam_next;
    walk_t                   walk_reg, walk_next;

    // output register
    logic                    out_valid_reg, out_valid_next;
    logic signed [OUT_W-1:0] px_reg, px_next;
    logic signed [OUT_W-1:0] py_reg, py_next;
    logic                    last_reg, last_next;

    walk_t                   walk_step;
    logic signed [OUT_W-1:0] dx;
    logic signed [OUT_W-1:0] dy;
    logic                    step_last;
    logic                    produces;
    logic                    out_free;
    logic                    advance;
    logic                    s_fire;
    logic [31:0]             cx_in_wide;
    logic [31:0]             cy_in_wide;
    logic [31:0]             cx_wide;
    logic [31:0]             cy_wide;
    logic [DIAM_W-1:0]       new_diam;

    mcpg_walk u_walk (
        .cur     (walk_reg),
        .shape   (shape_reg),
        .diam    (diam_reg),
        .nxt     (walk_step),
        .dx      (dx),
        .dy      (dy),
        .is_last (step_last)
    );

    assign produces      = (stg_func_reg == FUNC_STEP) && walk_reg.busy;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = stg_valid_reg && (out_free || !produces);
    assign s_axis_tready = !stg_valid_reg || advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign cx_in_wide = 32'(stg_cx_reg);
    assign cy_in_wide = 32'(stg_cy_reg);
    assign cx_wide    = 32'(cx_reg);
    assign cy_wide    = 32'(cy_reg);
    assign new_diam   = {stg_rad_reg, 1'b0};

    always_comb begin
        stg_valid_next = s_fire ? 1'b1 : (advance ? 1'b0 : stg_valid_reg);

        cx_next    = cx_reg;
        cy_next    = cy_reg;
        shape_next = shape_reg;
        diam_next  = diam_reg;
        walk_next  = walk_reg;

        out_valid_next = out_free ? 1'b0 : out_valid_reg;
        px_next        = px_reg;
        py_next        = py_reg;
        last_next      = last_reg;

        if (advance) begin
            if (stg_func_reg == FUNC_START) begin
                cx_next          = cx_in_wide[COORD_BITS-1:0];
                cy_next          = cy_in_wide[COORD_BITS-1:0];
                shape_next       = stg_shape_reg;
                diam_next        = new_diam;
                walk_next.x_ofs  = OFS_W'(stg_rad_reg) - OFS_W'(1);
                walk_next.y_ofs  = '0;
                walk_next.step_x = STEP_W'(1);
                walk_next.step_y = STEP_W'(1);
                walk_next.err    = ERR_W'(1) - ERR_W'(new_diam);
                walk_next.idx    = '0;
                walk_next.busy   = (stg_rad_reg != '0) && (stg_shape_reg <= SHAPE_FULL);
            end else if (walk_reg.busy) begin
                walk_next      = walk_step;
                out_valid_next = 1'b1;
                px_next        = OUT_W'(cx_wide[OUT_W-1:0]) + dx;
                py_next        = OUT_W'(cy_wide[OUT_W-1:0]) + dy;
                last_next      = step_last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_valid_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            walk_reg.x_ofs  <= '0;
            walk_reg.y_ofs  <= '0;
            walk_reg.step_x <= STEP_W'(1);
            walk_reg.step_y <= STEP_W'(1);
            walk_reg.err    <= '0;
            walk_reg.idx    <= '0;
            walk_reg.busy   <= 1'b0;
        end else begin
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
            walk_reg      <= walk_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            stg_func_reg  <= s_axis_tuser;
            stg_cx_reg    <= s_axis_tdata[11:0];
            stg_cy_reg    <= s_axis_tdata[23:12];
            stg_rad_reg   <= s_axis_tdata[34:24];
            stg_shape_reg <= s_axis_tdata[37:35];
        end
        cx_reg    <= cx_next;
        cy_reg    <= cy_next;
        shape_reg <= shape_next;
        diam_reg  <= diam_next;
        px_reg    <= px_next;
        py_reg    <= py_next;
        last_reg  <= last_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, py_reg, px_reg};
    assign m_axis_tlast  = last_reg;

endmodule

// ===== rtl/core/mcpg_checker.sv =====
// mcpg_checker: port-level checks on the midpoint circle core, and its bind
// depends on mcpg_pkg and midpoint_circle_point_generator_core
module mcpg_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic [mcpg_pkg::S_DATA_W-1:0] s_axis_tdata,
    input logic                          s_axis_tuser,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [mcpg_pkg::M_DATA_W-1:0] m_axis_tdata,
    input logic                          m_axis_tlast
);
    import mcpg_pkg::*;

    logic s_fire_seen;
    assign s_fire_seen = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '1 || s_axis_tuser);

    // a stalled point keeps its word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("point changed while stalled");

    // an empty output register never holds back the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with the output register empty");

    // reset empties the output register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("output valid right after reset");

    // an empty core can take a word after reset
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> s_axis_tready || s_fire_seen)
        else $error("input not ready after reset");

endmodule

bind midpoint_circle_point_generator_core mcpg_checker u_mcpg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== verif/circle_point_checker.sv =====
// circle_point_checker: watches both stream channels of the midpoint circle core,
// predicts each point from the accepted words and compares it with the emitted one
// depends on mcpg_pkg for widths and shape codes
module circle_point_checker
    import mcpg_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_axis_tvalid,
    input  logic                s_axis_tready,
    // centre_x [11:0], centre_y [23:12], radius [34:24], shape [37:35], zero fill
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // func [0]
    input  logic                s_axis_tuser,
    input  logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // point_x [13:0], point_y [27:14], zero fill
    input  logic [M_DATA_W-1:0] m_axis_tdata,
    input  logic                m_axis_tlast,
    output int                  fail_count,
    output int                  pending
);

    localparam int CX_LO    = 0;
    localparam int CY_LO    = CIN_W;
    localparam int RAD_LO   = 2 * CIN_W;
    localparam int SHAPE_LO = 2 * CIN_W + RAD_W;
    localparam int PRINT_MAX = 40;

    // point codes per shape, slot k in bits [3k+2:3k]; bit0 swap, bit1 negate x, bit2 negate y
    localparam logic [4:0][23:0] PT_ROWS = {
        24'o37152604,   // full
        24'o00001504,   // right
        24'o00003726,   // left
        24'o00003120,   // bottom
        24'o00007564    // top
    };

    typedef struct {
        logic [OUT_W-1:0] px;
        logic [OUT_W-1:0] py;
        logic             fin;
    } circle_pt_t;

    circle_pt_t          expected_pts[$];
    walk_t               walk;
    logic [CIN_W-1:0]    held_cx;
    logic [CIN_W-1:0]    held_cy;
    logic [SHAPE_W-1:0]  held_shape;
    logic [DIAM_W-1:0]   held_diam;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [OUT_W-1:0] got,
                                   input logic [OUT_W-1:0] want);
        if (fail_count < PRINT_MAX)
            $display("mismatch %s: got 0x%h want 0x%h", what, got, want);
        fail_count++;
    endtask

    task automatic clear_walk();
        walk.x_ofs  = '0;
        walk.y_ofs  = '0;
        walk.step_x = STEP_W'(1);
        walk.step_y = STEP_W'(1);
        walk.err    = '0;
        walk.idx    = '0;
        walk.busy   = 1'b0;
        held_cx     = '0;
        held_cy     = '0;
        held_shape  = '0;
        held_diam   = '0;
    endtask

    // advance the circle walk by one accepted word, queueing a point where one is due
    task automatic advance_circle(input logic fn, input logic [S_DATA_W-1:0] d);
        logic [RAD_W-1:0]  rad;
        logic [2:0]        code;
        logic [IDX_W-1:0]  last_slot;
        int                dx;
        int                dy;
        int                e;
        int                sx;
        int                sy;
        int                dm;
        circle_pt_t        pt;
        if (fn == FUNC_START) begin
            rad         = d[RAD_LO +: RAD_W];
            held_cx     = d[CX_LO +: CIN_W];
            held_cy     = d[CY_LO +: CIN_W];
            held_shape  = d[SHAPE_LO +: SHAPE_W];
            held_diam   = {rad, 1'b0};
            walk.x_ofs  = OFS_W'(int'(rad) - 1);
            walk.y_ofs  = '0;
            walk.step_x = STEP_W'(1);
            walk.step_y = STEP_W'(1);
            walk.err    = ERR_W'(1 - 2 * int'(rad));
            walk.idx    = '0;
            walk.busy   = (rad != '0) && (held_shape <= SHAPE_FULL);
        end else if (walk.busy) begin
            code = PT_ROWS[held_shape][3 * walk.idx +: 3];
            dx = code[PT_SWAP_BIT] ? walk.y_ofs : walk.x_ofs;
            dy = code[PT_SWAP_BIT] ? walk.x_ofs : walk.y_ofs;
            if (code[PT_NEGX_BIT]) dx = -dx;
            if (code[PT_NEGY_BIT]) dy = -dy;
            pt.px  = OUT_W'(int'(held_cx) + dx);
            pt.py  = OUT_W'(int'(held_cy) + dy);
            pt.fin = 1'b0;
            last_slot = (held_shape == SHAPE_FULL) ? IDX_W'(7) : IDX_W'(3);
            if (walk.idx == last_slot) begin
                // end of iteration: possibly advance y, then possibly retreat x as well
                walk.idx = '0;
                e  = walk.err;
                sy = walk.step_y;
                sx = walk.step_x;
                dm = held_diam;
                if (e <= 0) begin
                    walk.y_ofs = walk.y_ofs + 1'b1;
                    e  = e + sy;
                    sy = sy + 2;
                end
                if (e > 0) begin
                    walk.x_ofs = walk.x_ofs - 1'b1;
                    sx = sx + 2;
                    e  = e + sx - dm;
                end
                walk.err    = ERR_W'(e);
                walk.step_x = STEP_W'(sx);
                walk.step_y = STEP_W'(sy);
                if (walk.x_ofs < walk.y_ofs) begin
                    walk.busy = 1'b0;
                    pt.fin    = 1'b1;
                end
            end else begin
                walk.idx = walk.idx + 1'b1;
            end
            expected_pts.push_back(pt);
        end
    endtask

    always @(posedge aclk) begin
        circle_pt_t want;
        if (!aresetn) begin
            clear_walk();
            expected_pts.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                advance_circle(s_axis_tuser, s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_pts.size() == 0) begin
                    report_mismatch("unexpected point_x", m_axis_tdata[0 +: OUT_W], '0);
                end else begin
                    want = expected_pts.pop_front();
                    if (m_axis_tdata[0 +: OUT_W] != want.px)
                        report_mismatch("point_x", m_axis_tdata[0 +: OUT_W], want.px);
                    if (m_axis_tdata[OUT_W +: OUT_W] != want.py)
                        report_mismatch("point_y", m_axis_tdata[OUT_W +: OUT_W], want.py);
                    if (m_axis_tlast != want.fin)
                        report_mismatch("last", OUT_W'(m_axis_tlast), OUT_W'(want.fin));
                end
            end
        end
        pending <= expected_pts.size();
    end

endmodule

// ===== verif/tb_midpoint_circle_point_generator_core.sv =====
// tb_midpoint_circle_point_generator_core: drives start and step words into the circle
// core under several idle and stall patterns and gives the verdict
// depends on mcpg_pkg, midpoint_circle_point_generator_core and circle_point_checker
module tb_midpoint_circle_point_generator_core;
    import mcpg_pkg::*;

    localparam int PHASE_WORDS  = 450;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 8;
    localparam int CX_LO        = 0;
    localparam int CY_LO        = CIN_W;
    localparam int RAD_LO       = 2 * CIN_W;
    localparam int SHAPE_LO     = 2 * CIN_W + RAD_W;

    logic                aclk          = 1'b0;
    logic                aresetn       = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_axis_tdata  = '0;
    logic                s_axis_tuser  = FUNC_START;
    logic                m_axis_tready = 1'b0;
    wire                 s_axis_tready;
    wire                 m_axis_tvalid;
    wire [M_DATA_W-1:0]  m_axis_tdata;
    wire                 m_axis_tlast;
    int                  fail_count;
    int                  pending;
    int                  send_idle_pct  = 0;
    int                  sink_stall_pct = 0;
    int                  words_sent     = 0;
    int                  quiet_cycles   = 0;

    midpoint_circle_point_generator_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    circle_point_checker point_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // watchdog: any cycle without a word moving on either channel counts
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic fn, input logic [S_DATA_W-1:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= fn;
        s_axis_tdata  <= d;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic start_circle(input logic [CIN_W-1:0] cx, input logic [CIN_W-1:0] cy,
                                input logic [RAD_W-1:0] rad, input logic [SHAPE_W-1:0] shp);
        logic [S_DATA_W-1:0] d;
        d = '0;
        d[CX_LO +: CIN_W]      = cx;
        d[CY_LO +: CIN_W]      = cy;
        d[RAD_LO +: RAD_W]     = rad;
        d[SHAPE_LO +: SHAPE_W] = shp;
        send_word(FUNC_START, d);
    endtask

    // step words carry random payload, which the block must ignore
    task automatic step_words(input int n);
        repeat (n) send_word(FUNC_STEP, S_DATA_W'({$urandom, $urandom}));
    endtask

    task automatic random_circle();
        int                 roll;
        int                 rad;
        int                 per_iter;
        int                 n_steps;
        logic [SHAPE_W-1:0] shp;
        roll = $urandom_range(99);
        if (roll < 8) begin
            // ignored starts: zero radius or undefined shape
            if ($urandom_range(1) == 0)
                start_circle(CIN_W'($urandom), CIN_W'($urandom), '0,
                             SHAPE_W'($urandom_range(0, 7)));
            else
                start_circle(CIN_W'($urandom), CIN_W'($urandom), RAD_W'($urandom),
                             SHAPE_W'($urandom_range(5, 7)));
            step_words($urandom_range(1, 3));
        end else if (roll < 12) begin
            // wide radius, cut short by the next start
            start_circle(CIN_W'($urandom), CIN_W'($urandom), RAD_W'($urandom),
                         SHAPE_W'($urandom_range(0, 4)));
            step_words($urandom_range(1, 40));
        end else begin
            rad = $urandom_range(1, 24);
            shp = SHAPE_W'($urandom_range(0, 4));
            per_iter = (shp == SHAPE_FULL) ? 8 : 4;
            // enough steps to finish the circle, with a few idle steps past the end
            n_steps = per_iter * (rad * 3 / 4 + 2);
            if ($urandom_range(4) == 0)
                n_steps = $urandom_range(1, n_steps);
            start_circle(CIN_W'($urandom), CIN_W'($urandom), RAD_W'(rad), shp);
            step_words(n_steps);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int n_words);
        int stop_at;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at) random_circle();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        step_words(1);
        start_circle(12'd100, 12'd100, 11'd1, SHAPE_FULL);
        step_words(8);
        start_circle(12'd0, 12'd4095, 11'd2047, SHAPE_TOP);
        step_words(2);
        // restart while busy, opposite corner
        start_circle(12'd4095, 12'd0, 11'd2047, SHAPE_FULL);
        step_words(2);
        start_circle(12'd2048, 12'd2048, 11'd0, SHAPE_FULL);
        step_words(1);
        start_circle(12'd50, 12'd60, 11'd5, 3'd6);
        step_words(1);
        start_circle(12'd7, 12'd9, 11'd1, SHAPE_LEFT);
        step_words(4);

        run_phase(0, 0, PHASE_WORDS);
        run_phase(82, 0, PHASE_WORDS);
        run_phase(0, 82, PHASE_WORDS);
        run_phase(23, 23, PHASE_WORDS);
        s_axis_tvalid <= 1'b0;

        do @(posedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
